@@ sv/btlv_pkg.sv @@
// ----------------------------------------------------------------------------
// BASIC text line validator package
// Shared types, byte codes and sizes for the line validator unit.
// ----------------------------------------------------------------------------
package btlv_pkg;

	// Byte codes that the classifier looks for.
	localparam logic [7:0] CR_BYTE    = 8'd13;
	localparam logic [7:0] SPACE_BYTE = 8'd32;
	localparam logic [7:0] ZERO_CHAR  = 8'h30;
	localparam logic [7:0] NINE_CHAR  = 8'h39;

	// Largest legal line number.
	localparam logic [19:0] NUMBER_MAX = 20'd65535;

	// Configuration register indexes.
	localparam logic CFG_MAX_LINE_LENGTH   = 1'b0;
	localparam logic CFG_MAX_PROGRAM_BYTES = 1'b1;

	// Configuration reset values.
	localparam logic [7:0]  MAX_LINE_RESET    = 8'd255;
	localparam logic [15:0] MAX_PROGRAM_RESET = 16'd32768;

	// Classified item queue between front and back.
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Result queue inside the back part.
	localparam int unsigned RES_DEPTH = 4;
	localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
	localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

	// Phase of the line being parsed.
	typedef enum logic [1:0] {
		PH_DIGITS_EXPECTED = 2'd0,
		PH_DIGITS          = 2'd1,
		PH_SPACES          = 2'd2,
		PH_TEXT            = 2'd3
	} phase_t;

	// Kind of result item.
	typedef enum logic [1:0] {
		KIND_LINE   = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	// One byte after classification.
	typedef struct packed {
		logic       is_cr;
		logic       is_ctrl;
		logic       is_space;
		logic       is_digit;
		logic [3:0] digit;
		logic       last;
	} class_item_t;

	// One result item.
	typedef struct packed {
		kind_t       kind;
		logic [15:0] number;
		logic        last;
	} result_t;

	// Handshake between the queue and the back part.
	typedef struct packed {
		logic        valid;
		class_item_t item;
	} q_head_t;

endpackage

@@ sv/btlv_front.sv @@
// ----------------------------------------------------------------------------
// BASIC text line validator front
// Accepts bytes and registers their classification for the queue.
// ----------------------------------------------------------------------------
module btlv_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_program,
	input  logic                   q_full,
	output logic                   q_push,
	output btlv_pkg::class_item_t  q_item
);

	logic                  valid_s1;
	btlv_pkg::class_item_t item_s1;
	btlv_pkg::class_item_t item_c;
	logic                  accept;

	// Classify the incoming byte.
	always_comb begin
		item_c.is_cr    = (data_byte == btlv_pkg::CR_BYTE);
		item_c.is_ctrl  = (data_byte < btlv_pkg::SPACE_BYTE) &&
		                  (data_byte != btlv_pkg::CR_BYTE);
		item_c.is_space = (data_byte == btlv_pkg::SPACE_BYTE);
		item_c.is_digit = (data_byte >= btlv_pkg::ZERO_CHAR) &&
		                  (data_byte <= btlv_pkg::NINE_CHAR);
		item_c.digit    = 4'(data_byte - btlv_pkg::ZERO_CHAR);
		item_c.last     = end_of_program;
	end

	// The stage holds while the queue is full.
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = valid_s1 && !q_full;
	assign q_item   = item_s1;

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_c;
		end
	end

endmodule

@@ sv/btlv_queue.sv @@
// ----------------------------------------------------------------------------
// BASIC text line validator queue
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module btlv_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  btlv_pkg::class_item_t push_item,
	output logic                  full,
	input  logic                  pop,
	output btlv_pkg::q_head_t     head
);

	btlv_pkg::class_item_t              mem_q [btlv_pkg::Q_DEPTH];
	logic [btlv_pkg::Q_PTR_W-1:0]       wr_ptr_q;
	logic [btlv_pkg::Q_PTR_W-1:0]       rd_ptr_q;
	logic [btlv_pkg::Q_CNT_W-1:0]       count_q;
	logic                               do_push;
	logic                               do_pop;

	assign full       = (count_q == btlv_pkg::Q_CNT_W'(btlv_pkg::Q_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ sv/btlv_back.sv @@
// ----------------------------------------------------------------------------
// BASIC text line validator back
// Applies classified bytes to the line parser and queues the results.
// ----------------------------------------------------------------------------
module btlv_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data,
	input  btlv_pkg::q_head_t head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        kind,
	output logic [15:0]       line_number,
	output logic              verdict_last
);

	// Configuration.
	logic [7:0]  max_line_q;
	logic [15:0] max_prog_q;

	// Parser state.
	logic [7:0]       line_offset_q;
	logic [15:0]      byte_count_q;
	btlv_pkg::phase_t phase_q;
	logic [15:0]      acc_q;
	logic [15:0]      prev_q;
	logic             rejected_q;

	// Next state and results.
	logic [7:0]        line_offset_d;
	logic [15:0]       byte_count_d;
	btlv_pkg::phase_t  phase_d;
	logic [15:0]       acc_d;
	logic [15:0]       prev_d;
	logic              rejected_d;
	btlv_pkg::result_t res_a;
	btlv_pkg::result_t res_b;
	logic [1:0]        n_res;

	// Result queue.
	btlv_pkg::result_t              res_mem_q [btlv_pkg::RES_DEPTH];
	logic [btlv_pkg::RES_PTR_W-1:0] res_wr_q;
	logic [btlv_pkg::RES_PTR_W-1:0] res_rd_q;
	logic [btlv_pkg::RES_CNT_W-1:0] res_cnt_q;
	logic [btlv_pkg::RES_CNT_W-1:0] res_free;
	logic                           out_pop;
	logic [btlv_pkg::RES_PTR_W-1:0] res_wr_b;
	btlv_pkg::result_t              res_head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_line_q <= btlv_pkg::MAX_LINE_RESET;
			max_prog_q <= btlv_pkg::MAX_PROGRAM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				btlv_pkg::CFG_MAX_LINE_LENGTH:   max_line_q <= cfg_data[7:0];
				btlv_pkg::CFG_MAX_PROGRAM_BYTES: max_prog_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Output side of the result queue.
	assign res_head     = res_mem_q[res_rd_q];
	assign out_valid    = (res_cnt_q != '0);
	assign kind         = res_head.kind;
	assign line_number  = res_head.number;
	assign verdict_last = res_head.last;
	assign out_pop      = out_valid && !out_stall;

	// An item is taken only when both of its possible results fit.
	assign res_free = btlv_pkg::RES_CNT_W'(btlv_pkg::RES_DEPTH) - res_cnt_q +
	                  btlv_pkg::RES_CNT_W'(out_pop);
	assign pop      = head.valid && (res_free >= btlv_pkg::RES_CNT_W'(2));

	// Parser update for the item at the queue head.
	always_comb begin
		logic        rej;
		logic [19:0] v;
		rej           = rejected_q;
		line_offset_d = line_offset_q;
		byte_count_d  = byte_count_q;
		phase_d       = phase_q;
		acc_d         = acc_q;
		prev_d        = prev_q;
		res_a         = '{kind: btlv_pkg::KIND_LINE, number: '0, last: 1'b0};
		res_b         = '{kind: btlv_pkg::KIND_LINE, number: '0, last: 1'b0};
		n_res         = 2'd0;
		v             = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) +
		                {16'd0, head.item.digit};

		// Program length limit.
		if (!rej) begin
			if (byte_count_q >= max_prog_q) begin
				rej = 1'b1;
			end else begin
				byte_count_d = byte_count_q + 16'd1;
			end
		end

		// Line parsing.
		if (!rej) begin
			if (head.item.is_cr) begin
				if (phase_q != btlv_pkg::PH_TEXT || acc_q == '0 || acc_q <= prev_q) begin
					rej = 1'b1;
				end else begin
					prev_d        = acc_q;
					res_a         = '{kind: btlv_pkg::KIND_LINE, number: acc_q, last: 1'b0};
					n_res         = 2'd1;
					line_offset_d = '0;
					phase_d       = btlv_pkg::PH_DIGITS_EXPECTED;
					acc_d         = '0;
				end
			end else if (head.item.is_ctrl || line_offset_q >= max_line_q) begin
				rej = 1'b1;
			end else begin
				line_offset_d = line_offset_q + 8'd1;
				case (phase_q)
					btlv_pkg::PH_DIGITS_EXPECTED, btlv_pkg::PH_DIGITS: begin
						if (head.item.is_digit) begin
							if (v > btlv_pkg::NUMBER_MAX) begin
								rej = 1'b1;
							end else begin
								acc_d   = v[15:0];
								phase_d = btlv_pkg::PH_DIGITS;
							end
						end else if (phase_q == btlv_pkg::PH_DIGITS_EXPECTED) begin
							rej = 1'b1;
						end else if (head.item.is_space) begin
							phase_d = btlv_pkg::PH_SPACES;
						end else begin
							phase_d = btlv_pkg::PH_TEXT;
						end
					end
					btlv_pkg::PH_SPACES: begin
						if (!head.item.is_space) begin
							phase_d = btlv_pkg::PH_TEXT;
						end
					end
					default: ;
				endcase
			end
		end

		// Final byte gives the verdict and clears the program state.
		if (head.item.last) begin
			if (!rej && !head.item.is_cr) begin
				rej = 1'b1;
			end
			if (n_res == 2'd1) begin
				res_b = '{kind: rej ? btlv_pkg::KIND_REJECT : btlv_pkg::KIND_ACCEPT,
				          number: '0, last: 1'b1};
				n_res = 2'd2;
			end else begin
				res_a = '{kind: rej ? btlv_pkg::KIND_REJECT : btlv_pkg::KIND_ACCEPT,
				          number: '0, last: 1'b1};
				n_res = 2'd1;
			end
			rej           = 1'b0;
			line_offset_d = '0;
			byte_count_d  = '0;
			phase_d       = btlv_pkg::PH_DIGITS_EXPECTED;
			acc_d         = '0;
			prev_d        = '0;
		end
		rejected_d = rej;
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_offset_q <= '0;
			byte_count_q  <= '0;
			phase_q       <= btlv_pkg::PH_DIGITS_EXPECTED;
			acc_q         <= '0;
			prev_q        <= '0;
			rejected_q    <= 1'b0;
		end else if (pop) begin
			line_offset_q <= line_offset_d;
			byte_count_q  <= byte_count_d;
			phase_q       <= phase_d;
			acc_q         <= acc_d;
			prev_q        <= prev_d;
			rejected_q    <= rejected_d;
		end
	end

	// Result queue pointers and count.
	assign res_wr_b = res_wr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (pop) begin
				res_wr_q <= res_wr_q + btlv_pkg::RES_PTR_W'(n_res);
			end
			if (out_pop) begin
				res_rd_q <= res_rd_q + 1'b1;
			end
			res_cnt_q <= res_cnt_q + btlv_pkg::RES_CNT_W'(pop ? n_res : 2'd0) -
			             btlv_pkg::RES_CNT_W'(out_pop);
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (pop && n_res != 2'd0) begin
			res_mem_q[res_wr_q] <= res_a;
		end
		if (pop && n_res == 2'd2) begin
			res_mem_q[res_wr_b] <= res_b;
		end
	end

`ifndef SYNTHESIS
	// The result queue never overfills.
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q <= btlv_pkg::RES_CNT_W'(btlv_pkg::RES_DEPTH))
		else $error("result queue overflow");

	// A line number result carries a nonzero number and is never the verdict.
	a_line_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && res_head.kind == btlv_pkg::KIND_LINE) |->
		(!res_head.last && res_head.number != '0))
		else $error("bad line number result");

	// A final byte clears the program state.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.item.last) |=>
		(byte_count_q == '0 && !rejected_q && prev_q == '0))
		else $error("program state not cleared after verdict");

	// Rejection sticks until the final byte.
	a_reject_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(rejected_q && !(pop && head.item.last)) |=> rejected_q)
		else $error("rejection lost before verdict");
`endif

endmodule

@@ sv/basic_text_line_validator_unit.sv @@
// ----------------------------------------------------------------------------
// BASIC text line validator unit
// Checks a BASIC program in text form byte by byte and reports line numbers
// and a final accept or reject verdict.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_stall    data_byte, end_of_program
//   out      output     out_valid/out_stall  kind, line_number, verdict_last
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// One byte per cycle is sustained while in_stall stays low; a byte reaches
// the output through the front register, the queue and the result queue.
// The final byte of a program that ends a valid line gives two results, which
// leave the output one per cycle while out_stall is low.
// Reset clears the parser, both queues and loads the limit registers with
// 255 and 32768.
// The front stalls only while the item queue is full; the back stops taking
// items while its result queue has fewer than two free entries.
// ----------------------------------------------------------------------------
module basic_text_line_validator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_program,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [15:0] line_number,
	output logic        verdict_last,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic                  q_full;
	logic                  q_push;
	btlv_pkg::class_item_t q_item;
	logic                  q_pop;
	btlv_pkg::q_head_t     q_head;

	// Byte intake and classification.
	btlv_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.end_of_program (end_of_program),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_item         (q_item)
	);

	// Decoupling queue.
	btlv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head)
	);

	// Line parser and result queue.
	btlv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.head         (q_head),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.line_number  (line_number),
		.verdict_last (verdict_last)
	);

endmodule

@@ tb/tb_basic_text_line_validator_unit.sv @@
// ----------------------------------------------------------------------------
// Line validator unit testbench
// Streams BASIC text programs into the unit one byte per item, with random
// gaps on the input and random stalls on the output. A parser in the bench
// tracks every accepted byte and queues the line numbers and verdicts that
// the unit must report. The unit's results are compared in order. Short
// directed programs cover acceptance and each rejection but the length
// limits. Random programs, mostly well formed and partly broken, then run
// under several limit settings.
// ----------------------------------------------------------------------------
module tb_basic_text_line_validator_unit;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned END_CYCLES   = 20;
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam logic [7:0]  CTRL_SAMPLE  = 8'h01;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte      = 8'h00;
	logic        end_of_program = 1'b0;
	logic        out_valid;
	logic        out_stall      = 1'b0;
	logic [1:0]  kind;
	logic [15:0] line_number;
	logic        verdict_last;
	logic        cfg_we         = 1'b0;
	logic        cfg_index      = 1'b0;
	logic [15:0] cfg_data       = 16'h0000;

	// Parser copy of the limit registers and the program state.
	int unsigned      line_limit = btlv_pkg::MAX_LINE_RESET;
	int unsigned      prog_limit = btlv_pkg::MAX_PROGRAM_RESET;
	int unsigned      line_len   = 0;
	int unsigned      prog_bytes = 0;
	btlv_pkg::phase_t line_phase = btlv_pkg::PH_DIGITS_EXPECTED;
	int unsigned      line_num   = 0;
	int unsigned      prev_num   = 0;
	bit               prog_dead  = 1'b0;

	// Line numbers and verdicts that the unit still owes.
	btlv_pkg::result_t line_reports_due[$];

	int unsigned mismatches   = 0;
	int unsigned stall_left   = 0;
	int unsigned quiet_cycles = 0;
	bit          idle_on      = 1'b1;
	bit          stall_on     = 1'b1;

	basic_text_line_validator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.end_of_program(end_of_program),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.line_number   (line_number),
		.verdict_last  (verdict_last),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	// Put one report at the tail of the list of reports due.
	function automatic void add_report(input btlv_pkg::result_t rep);
		line_reports_due.insert(line_reports_due.size(), rep);
	endfunction

	// Put one byte at the end of a program.
	function automatic void append_byte(ref logic [7:0] prog[$], input logic [7:0] b);
		prog.insert(prog.size(), b);
	endfunction

	// Advance the program parser by one accepted byte and queue what it reports.
	task automatic parse_program_byte(input logic [7:0] b, input logic eop);
		int unsigned grown;
		bit          is_digit;
		is_digit = (b >= btlv_pkg::ZERO_CHAR) && (b <= btlv_pkg::NINE_CHAR);
		if (!prog_dead) begin
			if (prog_bytes >= prog_limit)
				prog_dead = 1'b1;
			else
				prog_bytes++;
		end
		if (!prog_dead) begin
			if (b == btlv_pkg::CR_BYTE) begin
				if (line_phase != btlv_pkg::PH_TEXT || line_num == 0 ||
				    line_num <= prev_num) begin
					prog_dead = 1'b1;
				end else begin
					prev_num = line_num;
					add_report('{kind: btlv_pkg::KIND_LINE, number: 16'(line_num),
						last: 1'b0});
					line_len   = 0;
					line_phase = btlv_pkg::PH_DIGITS_EXPECTED;
					line_num   = 0;
				end
			end else if (b < btlv_pkg::SPACE_BYTE || line_len >= line_limit) begin
				prog_dead = 1'b1;
			end else begin
				line_len++;
				if (line_phase == btlv_pkg::PH_DIGITS_EXPECTED ||
				    line_phase == btlv_pkg::PH_DIGITS) begin
					if (is_digit) begin
						grown = line_num * 10 + (b - btlv_pkg::ZERO_CHAR);
						if (grown > btlv_pkg::NUMBER_MAX) begin
							prog_dead = 1'b1;
						end else begin
							line_num   = grown;
							line_phase = btlv_pkg::PH_DIGITS;
						end
					end else if (line_phase == btlv_pkg::PH_DIGITS_EXPECTED) begin
						prog_dead = 1'b1;
					end else begin
						line_phase = (b == btlv_pkg::SPACE_BYTE) ?
							btlv_pkg::PH_SPACES : btlv_pkg::PH_TEXT;
					end
				end else if (line_phase == btlv_pkg::PH_SPACES &&
				             b != btlv_pkg::SPACE_BYTE) begin
					line_phase = btlv_pkg::PH_TEXT;
				end
			end
		end
		// The final byte always gives a verdict and starts a fresh program.
		if (eop) begin
			if (b != btlv_pkg::CR_BYTE)
				prog_dead = 1'b1;
			add_report('{kind: prog_dead ? btlv_pkg::KIND_REJECT : btlv_pkg::KIND_ACCEPT,
				number: 16'd0, last: 1'b1});
			line_len   = 0;
			prog_bytes = 0;
			line_phase = btlv_pkg::PH_DIGITS_EXPECTED;
			line_num   = 0;
			prev_num   = 0;
			prog_dead  = 1'b0;
		end
	endtask

	// Offer one byte after a random gap and hold it until the unit takes it.
	task automatic send_byte(input logic [7:0] b, input logic eop);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		data_byte      <= b;
		end_of_program <= eop;
		do @(posedge clk); while (in_stall);
		parse_program_byte(b, eop);
	endtask

	// Send a whole program; the final byte carries the end flag.
	task automatic send_program(ref logic [7:0] prog[$]);
		foreach (prog[i])
			send_byte(prog[i], i == prog.size() - 1);
	endtask

	// Directed programs use '|' for CR and '^' for a control byte.
	task automatic send_string(input string s);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (c == "|")
				c = btlv_pkg::CR_BYTE;
			else if (c == "^")
				c = CTRL_SAMPLE;
			send_byte(c, i == s.len() - 1);
		end
	endtask

	// Stop sending and wait until every report has come out.
	task automatic drain_reports();
		in_valid <= 1'b0;
		while (line_reports_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] value);
		drain_reports();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == btlv_pkg::CFG_MAX_LINE_LENGTH)
			line_limit = value[7:0];
		else
			prog_limit = value;
	endtask

	task automatic set_limits(input int unsigned line_max, input int unsigned prog_max);
		write_reg(btlv_pkg::CFG_MAX_LINE_LENGTH, 16'(line_max));
		write_reg(btlv_pkg::CFG_MAX_PROGRAM_BYTES, 16'(prog_max));
	endtask

	// Build a random program: mostly increasing numbered lines, sometimes broken.
	function automatic void build_program(ref logic [7:0] prog[$]);
		int unsigned num;
		int unsigned spaces;
		int unsigned text_len;
		int unsigned pick;
		int unsigned idx;
		string       digits;
		logic [7:0]  c;
		num = 0;
		prog.delete();
		repeat ($urandom_range(1, 6)) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				num = $urandom_range(0, num);
			else if (pick == 1)
				num = $urandom_range(60000, 99999);
			else
				num = num + $urandom_range(1, 500);
			digits = $sformatf("%0d", num);
			for (int i = 0; i < digits.len(); i++)
				append_byte(prog, digits[i]);
			spaces = $urandom_range(0, 2);
			repeat (spaces) append_byte(prog, btlv_pkg::SPACE_BYTE);
			pick = $urandom_range(0, 39);
			if (pick == 0)
				text_len = 0;
			else if (pick == 1)
				text_len = $urandom_range(200, 260);
			else
				text_len = $urandom_range(1, 12);
			for (int i = 0; i < text_len; i++) begin
				// Right after the digits a digit would extend the number.
				if (i == 0) begin
					do c = 8'($urandom_range(33, 255));
					while (spaces == 0 && c >= btlv_pkg::ZERO_CHAR &&
					       c <= btlv_pkg::NINE_CHAR);
				end else begin
					c = 8'($urandom_range(32, 255));
				end
				append_byte(prog, c);
			end
			append_byte(prog, btlv_pkg::CR_BYTE);
		end
		// About one program in five gets damaged.
		if ($urandom_range(0, 4) == 0) begin
			idx = $urandom_range(0, prog.size() - 1);
			case ($urandom_range(0, 3))
			0: begin
				prog[idx] = 8'($urandom_range(0, 255));
			end
			1: begin
				if (prog.size() > 1)
					void'(prog.pop_back());
			end
			2: begin
				prog.insert(idx, 8'($urandom_range(0, 31)));
			end
			default: begin
				prog.delete();
				repeat ($urandom_range(1, 20)) append_byte(prog, 8'($urandom_range(0, 255)));
			end
			endcase
		end
	endfunction

	// Well-formed program under the reset limits, with the largest line number.
	task automatic test_accepted_program();
		send_string("1 9|65535Y|");
	endtask

	// One program for each reason a program is rejected, the length limits apart.
	task automatic test_malformed_programs();
		send_string("0A|");
		send_string("A|");
		send_string("65536|");
		send_string("5 |");
		send_string("5A");
		send_string("^|");
		send_string("7A|7B|");
	endtask

	// Random programs under a sequence of limit settings, extremes included.
	task automatic test_random_programs();
		logic [7:0]  prog[$];
		int unsigned budget;
		int unsigned phase_bytes;
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
			0: begin
				set_limits(255, 32768);
			end
			1: begin
				set_limits(1, 32768);
			end
			2: begin
				set_limits(255, 1);
			end
			3: begin
				set_limits(1, 1);
			end
			9: begin
				set_limits(255, 32768);
			end
			default: begin
				set_limits($urandom_range(2, 60), $urandom_range(8, 600));
			end
			endcase
			budget      = (ph >= 1 && ph <= 3) ? 40 : 180;
			phase_bytes = 0;
			while (phase_bytes < budget) begin
				idle_on  = ($urandom_range(0, 3) != 0);
				stall_on = ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 9) == 0)
					drain_reports();
				build_program(prog);
				send_program(prog);
				phase_bytes += prog.size();
			end
		end
	endtask

	// Compare each report with the oldest one due, then draw the next stall.
	always @(posedge clk) begin
		btlv_pkg::result_t due;
		int unsigned       hold;
		if (arst_n && out_valid && !out_stall) begin
			if (line_reports_due.size() == 0) begin
				$display("%0t: report with none due: kind %0d number %0d last %0b",
					$time, kind, line_number, verdict_last);
				mismatches++;
			end else begin
				due = line_reports_due.pop_front();
				if (kind !== due.kind) begin
					$display("%0t: kind expected %0d, got %0d", $time, due.kind, kind);
					mismatches++;
				end
				if (line_number !== due.number) begin
					$display("%0t: line_number expected %0d, got %0d",
						$time, due.number, line_number);
					mismatches++;
				end
				if (verdict_last !== due.last) begin
					$display("%0t: verdict_last expected %0b, got %0b",
						$time, due.last, verdict_last);
					mismatches++;
				end
			end
			hold = stall_on ? $urandom_range(0, 15) : 0;
			stall_left <= hold;
			out_stall  <= (hold != 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= (stall_left > 1);
		end
	end

	// End the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("basic_text_line_validator_unit regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_accepted_program();
		test_malformed_programs();
		test_random_programs();
		in_valid <= 1'b0;
		while (line_reports_due.size() != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("basic_text_line_validator_unit regression: pass");
		else
			$display("basic_text_line_validator_unit regression: fail");
		$finish;
	end

endmodule
